// ===== hdl/ppsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppsu_pkg;

  // operation codes
  localparam logic [3:0] OP_UNPCKL_B = 4'd0;
  localparam logic [3:0] OP_UNPCKL_W = 4'd1;
  localparam logic [3:0] OP_UNPCKL_D = 4'd2;
  localparam logic [3:0] OP_UNPCKL_Q = 4'd3;
  localparam logic [3:0] OP_UNPCKH_B = 4'd4;
  localparam logic [3:0] OP_UNPCKH_W = 4'd5;
  localparam logic [3:0] OP_UNPCKH_D = 4'd6;
  localparam logic [3:0] OP_UNPCKH_Q = 4'd7;
  localparam logic [3:0] OP_PSHUFD   = 4'd8;
  localparam logic [3:0] OP_PSHUFHW  = 4'd9;
  localparam logic [3:0] OP_PSHUFLW  = 4'd10;

  // element width select for unpack
  localparam logic [1:0] EW_BYTE  = 2'd0;
  localparam logic [1:0] EW_WORD  = 2'd1;
  localparam logic [1:0] EW_DWORD = 2'd2;
  localparam logic [1:0] EW_QWORD = 2'd3;

  typedef logic [63:0]  half_t;
  typedef logic [127:0] vec_t;

  // interleave a and b elements, a element lower in each pair
  function automatic vec_t unpack_ilv(input half_t a, input half_t b,
                                      input logic [1:0] ew);
    vec_t r;
    r = '0;
    unique case (ew)
      EW_BYTE: begin
        for (int k = 0; k < 8; k++) begin
          r[16*k +: 8]     = a[8*k +: 8];
          r[16*k + 8 +: 8] = b[8*k +: 8];
        end
      end
      EW_WORD: begin
        for (int k = 0; k < 4; k++) begin
          r[32*k +: 16]      = a[16*k +: 16];
          r[32*k + 16 +: 16] = b[16*k +: 16];
        end
      end
      EW_DWORD: begin
        for (int k = 0; k < 2; k++) begin
          r[64*k +: 32]      = a[32*k +: 32];
          r[64*k + 32 +: 32] = b[32*k +: 32];
        end
      end
      EW_QWORD: begin
        r = {b, a};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ppsu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ppsu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [63:0] dest_low;
  logic [63:0] dest_high;
  logic [63:0] src_low;
  logic [63:0] src_high;
  logic [7:0]  order;

  modport source (output valid, req_type, dest_low, dest_high, src_low, src_high, order,
                  input ready);
  modport sink   (input valid, req_type, dest_low, dest_high, src_low, src_high, order,
                  output ready);
endinterface

interface ppsu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

`default_nettype wire

// ===== hdl/packed_unpack_shuffle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | payload                                          | handshake
// ---------+-----+--------------------------------------------------+-------------
// in_ch    | in  | req_type, dest_low/high, src_low/high, order     | valid/ready
// out_ch   | out | result_low, result_high                          | valid/ready
//
// Three register stages: operand capture, shuffle/half select, interleave
// and final select. An accepted word moves through the stage 1, 2 and 3
// registers in order; out valid is the stage 3 valid bit. One word per
// cycle while out_ch.ready holds: each stage loads whenever the next moves on.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Each stage has its own ready, so bubbles collapse and an output stall
// only backs up as far as the pipe is full; nothing is dropped or repeated.

module packed_unpack_shuffle_unit (
  input  wire             clk,
  input  wire             rst_n,
  ppsu_in_if.sink         in_ch,
  ppsu_out_if.source      out_ch
);
  import ppsu_pkg::*;

  typedef enum logic {
    K_UNPACK,
    K_SHUF
  } kind_t;

  // stage valids and per-stage readiness
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  logic ld1, ld2, ld3;

  // stage 1: captured operands
  logic [3:0] op1_r;
  half_t      dl1_r, dh1_r, sl1_r, sh1_r;
  logic [7:0] ord1_r;

  // stage 2: unpack halves or finished shuffle
  kind_t      kind2_r, kind2_nxt;
  logic [1:0] ew2_r, ew2_nxt;
  half_t      a2_r, b2_r, a2_nxt, b2_nxt;
  vec_t       shuf2_r, shuf2_nxt;

  // stage 3: result
  vec_t res3_r, res3_nxt;

  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1;
  assign ld1 = in_ch.valid && rdy1;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;

  assign v1_nxt = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_r);
  assign v2_nxt = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_r);
  assign v3_nxt = ld3 ? 1'b1 : ((v3_r && out_ch.ready) ? 1'b0 : v3_r);

  // stage 2 logic: pick unpack halves, run the immediate-driven shuffles
  always_comb begin
    vec_t       src;
    logic [1:0] sel;
    src       = {sh1_r, sl1_r};
    sel       = '0;
    a2_nxt    = op1_r[2] ? dh1_r : dl1_r;   // high unpack uses upper halves
    b2_nxt    = op1_r[2] ? sh1_r : sl1_r;
    ew2_nxt   = op1_r[1:0];
    kind2_nxt = (op1_r <= OP_UNPCKH_Q) ? K_UNPACK : K_SHUF;
    shuf2_nxt = '0;                          // unused codes give zero
    if (op1_r == OP_PSHUFD) begin
      for (int k = 0; k < 4; k++) begin
        sel = ord1_r[2*k +: 2];
        shuf2_nxt[32*k +: 32] = src[{sel, 5'b0} +: 32];
      end
    end else if (op1_r == OP_PSHUFHW) begin
      shuf2_nxt[63:0] = sl1_r;
      for (int k = 0; k < 4; k++) begin
        sel = ord1_r[2*k +: 2];
        shuf2_nxt[64 + 16*k +: 16] = sh1_r[{sel, 4'b0} +: 16];
      end
    end else if (op1_r == OP_PSHUFLW) begin
      shuf2_nxt[127:64] = sh1_r;
      for (int k = 0; k < 4; k++) begin
        sel = ord1_r[2*k +: 2];
        shuf2_nxt[16*k +: 16] = sl1_r[{sel, 4'b0} +: 16];
      end
    end
  end

  // stage 3 logic: interleave and final select
  always_comb begin
    unique case (kind2_r)
      K_UNPACK: res3_nxt = unpack_ilv(a2_r, b2_r, ew2_r);
      K_SHUF:   res3_nxt = shuf2_r;
      default:  res3_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      op1_r  <= in_ch.req_type;
      dl1_r  <= in_ch.dest_low;
      dh1_r  <= in_ch.dest_high;
      sl1_r  <= in_ch.src_low;
      sh1_r  <= in_ch.src_high;
      ord1_r <= in_ch.order;
    end
    if (ld2) begin
      kind2_r <= kind2_nxt;
      ew2_r   <= ew2_nxt;
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      shuf2_r <= shuf2_nxt;
    end
    if (ld3) begin
      res3_r <= res3_nxt;
    end
  end

  assign out_ch.valid       = v3_r;
  assign out_ch.result_low  = res3_r[63:0];
  assign out_ch.result_high = res3_r[127:64];

`ifndef ASSERT_OFF
  // input backpressure only when every stage is full and the output stalls
  a_bp_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && !out_ch.ready))
    else $error("input stalled without a full, stalled pipe");

  // a blocked stage 1 word holds its opcode
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(op1_r)))
    else $error("stage 1 word lost under stall");

  // a blocked stage 2 word holds its shuffle result
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(shuf2_r) && $stable(kind2_r)))
    else $error("stage 2 word lost under stall");
`endif

endmodule

`default_nettype wire
